// ===== hw/rtl/gfi_pkg.sv =====
// shared constants and helpers for the gf(2) polynomial inverse core
// no dependencies
package gfi_pkg;

  localparam int FIELD_BITS_DEF = 8;
  localparam int MAX_BITS = 64;
  localparam int DEG_W = 7;
  localparam logic [MAX_BITS-1:0] MOD_RESET = 64'h11B;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } eng_state_t;

  // queue entry status handed from front to engine
  typedef struct packed {
    logic valid;
    logic is_zero;
  } q_status_t;

  // index of the highest set bit; zero when no bit is set
  function automatic logic [DEG_W-1:0] poly_deg(input logic [MAX_BITS-1:0] p);
    logic [DEG_W-1:0] d;
    d = '0;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (p[i]) d = DEG_W'(i);
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/gfi_in_if.sv =====
// input channel of the polynomial inverse core: valid, ready, operand
// depends on nothing
interface gfi_in_if #(parameter int FIELD_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] operand_poly;
  modport source (output valid, output operand_poly, input ready);
  modport sink (input valid, input operand_poly, output ready);
endinterface

// ===== hw/rtl/gfi_out_if.sv =====
// result channel of the polynomial inverse core: valid, ready, inverse, flag
// depends on nothing
interface gfi_out_if #(parameter int FIELD_BITS = 8);
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] inverse_poly;
  logic                  has_inverse;
  modport source (output valid, output inverse_poly, output has_inverse, input ready);
  modport sink (input valid, input inverse_poly, input has_inverse, output ready);
endinterface

// ===== hw/rtl/gfi_front.sv =====
// front end: accepts operands into a two-word queue and flags zero operands
// depends on gfi_pkg
module gfi_front #(
  parameter int FIELD_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FIELD_BITS-1:0]   in_operand,
  output gfi_pkg::q_status_t      q_status,
  output logic [FIELD_BITS-1:0]   q_operand,
  input  logic                    q_pop
);
  import gfi_pkg::*;

  logic [FIELD_BITS-1:0] data_r [2];
  logic                  zero_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (cnt_r != 2'd0);

  assign q_status.valid   = (cnt_r != 2'd0);
  assign q_status.is_zero = zero_r[rd_ptr_r];
  assign q_operand        = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r[wr_ptr_r] <= in_operand;
      zero_r[wr_ptr_r] <= (in_operand == '0);
    end
  end
endmodule

// ===== hw/rtl/gfi_engine.sv =====
// back end: extended euclid, one xor-shift step or one remainder swap per cycle while running
// depends on gfi_pkg
module gfi_engine #(
  parameter int FIELD_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [FIELD_BITS:0]     modulus,
  input  gfi_pkg::q_status_t      q_status,
  input  logic [FIELD_BITS-1:0]   q_operand,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FIELD_BITS-1:0]   out_inverse,
  output logic                    out_has_inverse
);
  import gfi_pkg::*;

  localparam int PW = FIELD_BITS + 1;

  eng_state_t            state_r, state_nxt;
  logic [PW-1:0]         rp_r, rp_nxt, rc_r, rc_nxt, rem_r, rem_nxt;
  logic [FIELD_BITS-1:0] sp_r, sp_nxt, sc_r, sc_nxt, acc_r, acc_nxt;
  logic [FIELD_BITS-1:0] inv_r, inv_nxt;
  logic                  has_r, has_nxt;
  logic [DEG_W-1:0]      dc, dr, sh;
  logic                  can_sub;

  assign dc      = poly_deg(MAX_BITS'(rc_r));
  assign dr      = poly_deg(MAX_BITS'(rem_r));
  assign can_sub = (rem_r != '0) && (dr >= dc);
  assign sh      = dr - dc;

  assign out_valid       = (state_r == ST_DONE);
  assign out_inverse     = inv_r;
  assign out_has_inverse = has_r;
  assign q_pop           = (state_r == ST_IDLE) && q_status.valid;

  always_comb begin
    state_nxt = state_r;
    rp_nxt = rp_r; rc_nxt = rc_r; rem_nxt = rem_r;
    sp_nxt = sp_r; sc_nxt = sc_r; acc_nxt = acc_r;
    inv_nxt = inv_r; has_nxt = has_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_status.valid) begin
          rp_nxt  = modulus;
          rc_nxt  = PW'(q_operand);
          rem_nxt = modulus;
          sp_nxt  = '0;
          sc_nxt  = FIELD_BITS'(1);
          acc_nxt = '0;
          // zero operand: gcd is the modulus itself
          if (q_status.is_zero) begin
            has_nxt   = (modulus == PW'(1));
            inv_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (rc_r == '0) begin
          has_nxt   = (rp_r == PW'(1));
          inv_nxt   = (rp_r == PW'(1)) ? sp_r : '0;
          state_nxt = ST_DONE;
        end else if (can_sub) begin
          rem_nxt = rem_r ^ (rc_r << sh);
          acc_nxt = acc_r ^ (sc_r << sh);
        end else begin
          // quotient finished: rotate remainders and coefficients
          rp_nxt  = rc_r;
          rc_nxt  = rem_r;
          rem_nxt = rc_r;
          sp_nxt  = sc_r;
          sc_nxt  = acc_r;
          acc_nxt = sc_r;
        end
      end
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r  <= rp_nxt;
    rc_r  <= rc_nxt;
    rem_r <= rem_nxt;
    sp_r  <= sp_nxt;
    sc_r  <= sc_nxt;
    acc_r <= acc_nxt;
    inv_r <= inv_nxt;
    has_r <= has_nxt;
  end
endmodule

// ===== hw/rtl/gf2_poly_inverse_core.sv =====
// top level of the gf(2) polynomial inverse core
// depends on gfi_pkg, gfi_in_if, gfi_out_if, gfi_front, gfi_engine
//
// usage:
//   in_ch carries one operand polynomial per word (valid/ready). out_ch
//   returns one word per operand: the inverse modulo the configured
//   modulus and a flag that is set when gcd(operand, modulus) is 1; the
//   inverse reads zero when the flag is clear.
//   cfg_we/cfg_wdata write the modulus (reset value x^8+x^4+x^3+x+1); the user
//   writes it only while the core is idle, the core does not enforce this.
// throughput:
//   the engine does one xor-shift division step or one remainder swap per
//   cycle while running, on the single euclid datapath, and takes the next
//   operand only after the last result has been taken.
//   a two-word queue in front keeps accepting while the engine works.
// reset: queue emptied, engine idle, modulus back to its default.
// stall: a result waits in the engine's output register while out_ch.ready
//   is low; the queue fills up and then in_ch.ready drops.
module gf2_poly_inverse_core #(
  parameter int FIELD_BITS = gfi_pkg::FIELD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [FIELD_BITS:0]   cfg_wdata,
  gfi_in_if.sink                in_ch,
  gfi_out_if.source             out_ch
);
  import gfi_pkg::*;

  logic [FIELD_BITS:0]   modulus_r;
  q_status_t             q_status;
  logic [FIELD_BITS-1:0] q_operand;
  logic                  q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET[FIELD_BITS:0];
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  gfi_front #(.FIELD_BITS(FIELD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_operand (in_ch.operand_poly),
    .q_status   (q_status),
    .q_operand  (q_operand),
    .q_pop      (q_pop)
  );

  gfi_engine #(.FIELD_BITS(FIELD_BITS)) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .modulus         (modulus_r),
    .q_status        (q_status),
    .q_operand       (q_operand),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_inverse     (out_ch.inverse_poly),
    .out_has_inverse (out_ch.has_inverse)
  );
endmodule

// ===== hw/rtl/gfi_checker.sv =====
// port-level checks for the polynomial inverse core, bound to the top level
// depends on gf2_poly_inverse_core
module gfi_checker #(
  parameter int FIELD_BITS = 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FIELD_BITS-1:0] inverse_poly,
  input logic                  has_inverse
);
  a_no_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !has_inverse) |-> (inverse_poly == '0))
    else $error("inverse not zero without flag");

  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

  // an accepted operand passes the queue and the engine state register before any result shows
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(!rst_n) && !out_valid && in_valid && in_ready) |=> !out_valid)
    else $error("result without any work cycle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(inverse_poly)
      && $stable(has_inverse)))
    else $error("stalled result word changed");
endmodule

bind gf2_poly_inverse_core gfi_checker #(.FIELD_BITS(FIELD_BITS)) u_gfi_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .inverse_poly (out_ch.inverse_poly),
  .has_inverse  (out_ch.has_inverse)
);
